@@ design/osst_pkg.sv @@
`timescale 1ns / 1ps

package osst_pkg;

  localparam int KEY_W        = 32;
  localparam int ACT_W        = 3;
  localparam int STAT_W       = 2;
  localparam int CAPACITY_DEF = 64;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MEMBER = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SUCC   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PRED   = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic                    present;
    logic signed [KEY_W-1:0] found_key;
  } rsp_t;

  // Per-item commands broadcast to every cell during the update cycle
  typedef struct packed {
    logic ins;
    logic del;
    logic succ;
    logic pred;
  } cell_ctl_t;

endpackage

@@ design/osst_cell.sv @@
`timescale 1ns / 1ps

// One slot of the sorted table. Compares against the probe key, then
// shifts toward its neighbors on insert/delete and flags itself as the
// neighbor key for successor/predecessor.
module osst_cell #(
  parameter int CNT_W = 7,
  parameter int INDEX = 0
) (
  input  logic                             clk,
  input  logic                             cmp_en,
  input  logic signed [osst_pkg::KEY_W-1:0] probe_key,
  input  logic signed [osst_pkg::KEY_W-1:0] ins_key,
  input  logic [CNT_W-1:0]                 occ,
  input  osst_pkg::cell_ctl_t              ctl,
  input  logic signed [osst_pkg::KEY_W-1:0] key_l,
  input  logic                             lt_l,
  input  logic                             gt_l,
  input  logic signed [osst_pkg::KEY_W-1:0] key_r,
  input  logic                             lt_r,
  output logic signed [osst_pkg::KEY_W-1:0] key,
  output logic                             lt,
  output logic                             eq,
  output logic                             gt,
  output logic                             pick,
  output logic signed [osst_pkg::KEY_W-1:0] pick_key
);

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic vld;

  assign vld = occ > IDX;

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      lt <= vld && (key < probe_key);
      eq <= vld && (key == probe_key);
    end
    // cells below the lower bound hold; the rest shift
    if (ctl.ins && !lt) begin
      key <= lt_l ? ins_key : key_l;
    end else if (ctl.del && !lt) begin
      key <= key_r;
    end
  end

  assign gt       = vld && !lt && !eq;
  assign pick     = (ctl.succ && gt && !gt_l) || (ctl.pred && lt && !lt_r);
  assign pick_key = pick ? key : '0;

endmodule

@@ design/ordered_set_successor_table.sv @@
`timescale 1ns / 1ps

// Ordered set of distinct signed 32-bit keys, held sorted in a row of
// CAPACITY cells. An item is accepted when
// start is high and busy is low; in that edge every cell compares its key
// with the item's key (compare cycle), and in the next cycle (busy high)
// the cells shift one place left or right for delete/insert while the
// neighbor key for successor/predecessor is picked out of the row. done
// strobes for one cycle, registered from busy, with rsp valid only
// in that cycle; the receiver cannot hold it off, so capture it then. A
// new item may be accepted in the same cycle that done is high. The set
// is empty after reset with no clearing pass; slots past the fill count
// are never read. Insert of a new key into a full table is dropped with
// status FULL.
module ordered_set_successor_table #(
  parameter int CAPACITY = osst_pkg::CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  osst_pkg::req_t  req,
  output logic            done,
  output osst_pkg::rsp_t  rsp
);

  localparam int               CNT_W   = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]               occ;
  logic [osst_pkg::ACT_W-1:0]     act;
  logic signed [osst_pkg::KEY_W-1:0] item_key;
  osst_pkg::cell_ctl_t            ctl;
  osst_pkg::rsp_t                 rsp_next;
  logic                           cmp_en;
  logic                           present;
  logic                           any_pick;
  logic signed [osst_pkg::KEY_W-1:0] found;

  logic signed [osst_pkg::KEY_W-1:0] cell_key  [CAPACITY];
  logic signed [osst_pkg::KEY_W-1:0] cell_pkey [CAPACITY];
  logic [CAPACITY-1:0]            lt_vec;
  logic [CAPACITY-1:0]            eq_vec;
  logic [CAPACITY-1:0]            gt_vec;
  logic [CAPACITY-1:0]            pick_vec;

  assign cmp_en = start && !busy;

  // Cell row; ends tied so cell 0 sees "everything left is below" and the
  // last cell sees "nothing right is below".
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [osst_pkg::KEY_W-1:0] kl;
    logic signed [osst_pkg::KEY_W-1:0] kr;
    logic                              ltl;
    logic                              gtl;
    logic                              ltr;

    if (i == 0) begin : g_first
      assign kl  = '0;
      assign ltl = 1'b1;
      assign gtl = 1'b0;
    end else begin : g_mid_l
      assign kl  = cell_key[i-1];
      assign ltl = lt_vec[i-1];
      assign gtl = gt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign kr  = '0;
      assign ltr = 1'b0;
    end else begin : g_mid_r
      assign kr  = cell_key[i+1];
      assign ltr = lt_vec[i+1];
    end

    osst_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .cmp_en    (cmp_en),
      .probe_key (req.key),
      .ins_key   (item_key),
      .occ       (occ),
      .ctl       (ctl),
      .key_l     (kl),
      .lt_l      (ltl),
      .gt_l      (gtl),
      .key_r     (kr),
      .lt_r      (ltr),
      .key       (cell_key[i]),
      .lt        (lt_vec[i]),
      .eq        (eq_vec[i]),
      .gt        (gt_vec[i]),
      .pick      (pick_vec[i]),
      .pick_key  (cell_pkey[i])
    );
  end

  // At most one cell picks, so the found key is a plain OR over the row.
  always_comb begin
    found = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found = found | cell_pkey[i];
    end
  end

  assign present  = |eq_vec;
  assign any_pick = |pick_vec;

  // Update-cycle decode
  always_comb begin
    ctl = '0;
    rsp_next.status    = osst_pkg::ST_DONE;
    rsp_next.present   = present;
    rsp_next.found_key = '0;
    unique case (act) inside
      osst_pkg::ACT_INSERT: begin
        if (!present) begin
          if (occ >= CAP_CNT) begin
            rsp_next.status = osst_pkg::ST_FULL;
          end else begin
            ctl.ins = busy;
          end
        end
      end
      osst_pkg::ACT_DELETE: begin
        ctl.del = busy && present;
      end
      osst_pkg::ACT_SUCC, osst_pkg::ACT_PRED: begin
        ctl.succ = busy && (act == osst_pkg::ACT_SUCC);
        ctl.pred = busy && (act == osst_pkg::ACT_PRED);
        if (any_pick) begin
          rsp_next.found_key = found;
        end else begin
          rsp_next.status = osst_pkg::ST_NONE;
        end
      end
      default: begin
        // membership test and unused codes: report presence only
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      occ  <= '0;
    end else begin
      busy <= cmp_en;
      done <= busy;
      if (ctl.ins) begin
        occ <= occ + 1'b1;
      end else if (ctl.del) begin
        occ <= occ - 1'b1;
      end
    end
    if (cmp_en) begin
      act      <= req.action;
      item_key <= req.key;
    end
    if (busy) begin
      rsp <= rsp_next;
    end
  end

  // Fill count stays within the table
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CAP_CNT)
    else $error("occupancy above capacity");

  // Every accepted item is followed by busy and then the done strobe
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    cmp_en |=> busy ##1 done)
    else $error("missing result strobe");

  // Sorted row: at most one neighbor cell can be picked
  a_one_pick: assert property (@(posedge clk) disable iff (rst)
    busy |-> $onehot0(pick_vec))
    else $error("multiple cells picked");

  // Fill count only moves in the update cycle
  a_occ_stable: assert property (@(posedge clk) disable iff (rst)
    !busy |=> $stable(occ))
    else $error("occupancy changed outside update");

  // A dropped insert never concerns a key already present
  a_full_absent: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == osst_pkg::ST_FULL) |-> !rsp.present)
    else $error("full status on present key");

endmodule
